@@ design/dwvw_pkg.sv @@
// Shared types and constants for the DWVW sample decoder.
// Used by the controller, the datapath, the top level and the port checker.
package dwvw_pkg;

  localparam int MAX_WS_DEF     = 32;
  localparam int WS_MIN         = 8;
  localparam int WS_RST         = 16;
  localparam int CFG_WS_W       = 6;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;
  localparam int IN_W           = 8;
  localparam int OUT_W          = 32;
  localparam int BIT_CNT_W      = 3;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = 3'd7;
  localparam logic [0:0]           REG_WORD_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_UNARY,
    PH_MODSIGN,
    PH_MAG,
    PH_DSIGN,
    PH_EXTRA
  } phase_t;

  typedef enum logic [1:0] {
    DM_ZERO,
    DM_POS,
    DM_NEG,
    DM_NEG_EXTRA
  } delta_mode_t;

  typedef struct packed {
    logic        load;
    logic        shift;
    logic        unary_inc;
    logic        unary_clr;
    logic        dw_load;
    logic        acc_init;
    logic        acc_shift;
    logic        emit;
    delta_mode_t mode;
    logic        push;
    logic        push_last;
  } dp_cmd_t;

  typedef struct packed {
    logic bit_val;
    logic unary_zero;
    logic unary_limit;
    logic width_zero;
    logic width_one;
    logic new_width_zero;
    logic new_width_one;
    logic rem_last;
    logic acc_max;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/dwvw_ctrl.sv @@
// Controller of the DWVW decoder: byte sequencing and per-bit decode phase.
// Depends on dwvw_pkg; drives dwvw_dp through dp_cmd_t and reads dp_status_t.
module dwvw_ctrl
  import dwvw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  seq_state_t           st_r, st_nxt;
  phase_t               ph_r, ph_nxt, ph_dec;
  logic [BIT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  dp_cmd_t              bcmd;
  logic                 stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ph_r   <= PH_UNARY;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    bcmd   = '0;
    ph_dec = ph_r;
    case (ph_r)
      PH_UNARY: begin
        if (sts.bit_val) begin
          if (sts.unary_zero) begin
            if (sts.width_zero) begin
              bcmd.emit = 1'b1;
              bcmd.mode = DM_ZERO;
            end else begin
              bcmd.acc_init = 1'b1;
              ph_dec = sts.width_one ? PH_DSIGN : PH_MAG;
            end
          end else begin
            ph_dec = PH_MODSIGN;
          end
        end else begin
          bcmd.unary_inc = 1'b1;
          if (sts.unary_limit) begin
            ph_dec = PH_MODSIGN;
          end
        end
      end
      PH_MODSIGN: begin
        bcmd.dw_load   = 1'b1;
        bcmd.unary_clr = 1'b1;
        if (sts.new_width_zero) begin
          bcmd.emit = 1'b1;
          bcmd.mode = DM_ZERO;
          ph_dec = PH_UNARY;
        end else begin
          bcmd.acc_init = 1'b1;
          ph_dec = sts.new_width_one ? PH_DSIGN : PH_MAG;
        end
      end
      PH_MAG: begin
        bcmd.acc_shift = 1'b1;
        if (sts.rem_last) begin
          ph_dec = PH_DSIGN;
        end
      end
      PH_DSIGN: begin
        if (!sts.bit_val) begin
          bcmd.emit = 1'b1;
          bcmd.mode = DM_POS;
          ph_dec = PH_UNARY;
        end else if (sts.acc_max) begin
          ph_dec = PH_EXTRA;
        end else begin
          bcmd.emit = 1'b1;
          bcmd.mode = DM_NEG;
          ph_dec = PH_UNARY;
        end
      end
      PH_EXTRA: begin
        bcmd.emit = 1'b1;
        bcmd.mode = DM_NEG_EXTRA;
        ph_dec = PH_UNARY;
      end
      default: begin
        ph_dec = PH_UNARY;
      end
    endcase
  end

  assign stall = bcmd.emit && pend_r && !sts.out_free;

  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    cmd      = '0;
    in_ready = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          st_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stall) begin
          cmd       = bcmd;
          cmd.shift = 1'b1;
          ph_nxt    = ph_dec;
          cnt_nxt   = cnt_r + 1'b1;
          if (bcmd.emit) begin
            pend_nxt = 1'b1;
            if (pend_r) begin
              cmd.push      = 1'b1;
              cmd.push_last = 1'b0;
            end
          end
          if (cnt_r == BIT_LAST) begin
            st_nxt = pend_nxt ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          pend_nxt      = 1'b0;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/dwvw_dp.sv @@
// Datapath of the DWVW decoder: bit shifter, width and delta registers,
// sample adder, pending sample and output register. Depends on dwvw_pkg.
module dwvw_dp
  import dwvw_pkg::*;
#(
  parameter int MAX_WORD_SIZE = MAX_WS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_status_t          sts,
  input  logic [CFG_WS_W-1:0] word_size,
  input  logic [IN_W-1:0]     in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_sample,
  output logic                out_last
);

  localparam int SW   = MAX_WORD_SIZE;
  localparam int WSW  = $clog2(MAX_WORD_SIZE + 1);
  localparam int IXW  = $clog2(MAX_WORD_SIZE);
  localparam int UW   = $clog2(MAX_WORD_SIZE / 2 + 1);
  localparam int RW   = $clog2(MAX_WORD_SIZE);
  localparam int WW   = WSW + 2;
  localparam int SUB_STEPS = (3 * MAX_WORD_SIZE / 2 - WS_MIN + WS_MIN - 1) / WS_MIN;
  localparam int ADD_STEPS = (MAX_WORD_SIZE / 2 + WS_MIN - 1) / WS_MIN;

  logic [IN_W-1:0]  byte_r, byte_nxt;
  logic [UW-1:0]    unary_r, unary_nxt;
  logic [WSW-1:0]   dw_r, dw_nxt;
  logic [SW-1:0]    acc_r, acc_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [SW-1:0]    pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [WSW-1:0]   ws;
  logic [WSW-1:0]   ws_m1;
  logic [IXW-1:0]   top_idx;
  logic             b;
  logic [WSW-1:0]   dw_new;
  logic [WSW-1:0]   width_sel;
  logic [SW-1:0]    operand;
  logic             cin;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    sample;
  logic [SW-1:0]    acc_mask;
  logic             out_free;

  assign ws = (word_size < CFG_WS_W'(WS_MIN))        ? WSW'(WS_MIN) :
              (word_size > CFG_WS_W'(MAX_WORD_SIZE)) ? WSW'(MAX_WORD_SIZE) :
                                                       WSW'(word_size);
  assign ws_m1   = ws - 1'b1;
  assign top_idx = ws_m1[IXW-1:0];
  assign b       = byte_r[IN_W-1];

  always_comb begin
    logic signed [WW-1:0] dw_s;
    logic signed [WW-1:0] c_s;
    logic signed [WW-1:0] ws_s;
    logic signed [WW-1:0] raw;
    logic signed [WW-1:0] v;
    logic signed [WW-1:0] a;
    dw_s = $signed(WW'(dw_r));
    c_s  = $signed(WW'(unary_r));
    ws_s = $signed(WW'(ws));
    raw  = b ? (dw_s - c_s) : (dw_s + c_s);
    v    = raw;
    for (int k = 0; k < SUB_STEPS; k++) begin
      if (v > ws_s) begin
        v = v - ws_s;
      end
    end
    a = raw;
    for (int k = 0; k < ADD_STEPS; k++) begin
      if (a < 0) begin
        a = a + ws_s;
      end
    end
    dw_new = (raw < 0) ? a[WSW-1:0] : v[WSW-1:0];
  end

  assign width_sel = cmd.dw_load ? dw_new : dw_r;

  always_comb begin
    case (cmd.mode)
      DM_ZERO:      begin operand = '0;     cin = 1'b0; end
      DM_POS:       begin operand = acc_r;  cin = 1'b0; end
      DM_NEG:       begin operand = ~acc_r; cin = 1'b1; end
      DM_NEG_EXTRA: begin operand = ~acc_r; cin = !b;   end
      default:      begin operand = '0;     cin = 1'b0; end
    endcase
  end

  assign sum = cur_r + operand + SW'(cin);

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      sample[i]   = (i >= int'(ws)) ? sum[top_idx] : sum[i];
      acc_mask[i] = (i + 1 < int'(ws));
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    byte_nxt      = byte_r;
    unary_nxt     = unary_r;
    dw_nxt        = dw_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      byte_nxt = in_byte;
    end else if (cmd.shift) begin
      byte_nxt = {byte_r[IN_W-2:0], 1'b0};
    end
    if (cmd.unary_clr) begin
      unary_nxt = '0;
    end else if (cmd.unary_inc) begin
      unary_nxt = unary_r + 1'b1;
    end
    if (cmd.dw_load) begin
      dw_nxt = dw_new;
    end
    if (cmd.acc_init) begin
      acc_nxt = SW'(1);
      rem_nxt = RW'(width_sel - 1'b1);
    end else if (cmd.acc_shift) begin
      acc_nxt = {acc_r[SW-2:0], b};
      rem_nxt = rem_r - 1'b1;
    end
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'($signed(pend_r));
      out_last_nxt  = cmd.push_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      cur_nxt  = sample;
      pend_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unary_r     <= '0;
      dw_r        <= '0;
      acc_r       <= '0;
      rem_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unary_r     <= unary_nxt;
      dw_r        <= dw_nxt;
      acc_r       <= acc_nxt;
      rem_r       <= rem_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    sts.bit_val        = b;
    sts.unary_zero     = (unary_r == '0);
    sts.unary_limit    = ((WSW'(unary_r) + 1'b1) >= (ws >> 1));
    sts.width_zero     = (dw_r == '0);
    sts.width_one      = (dw_r == WSW'(1));
    sts.new_width_zero = (dw_new == '0);
    sts.new_width_one  = (dw_new == WSW'(1));
    sts.rem_last       = (rem_r == RW'(1));
    sts.acc_max        = (acc_r == acc_mask);
    sts.out_free       = out_free;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;
  assign out_last   = out_last_r;

endmodule

@@ design/dwvw_sample_decoder.sv @@
// Top level of the DWVW sample decoder: configuration register and glue.
// Instantiates dwvw_ctrl and dwvw_dp; depends on dwvw_pkg.
//
//   channel | direction | handshake              | payload
//   in_     | slave     | in_tvalid / in_tready   | in_tdata[7:0] = data_byte
//   out_    | master    | out_tvalid / out_tready | out_tdata[31:0] = audio_sample,
//           |           |                         | out_tlast = last_of_byte
//   cfg_    | APB slave | psel, penable, pready   | word_size at address 0
//
// One byte is taken in the idle cycle, then decoded one bit per cycle while no
// stall holds it; the bit chain through the shift register sets that pace.
// A byte that completes a sample then passes through a flush state to hand
// the last one out, waiting there until the output register is free.
// A full output register holds the bit sequence only when a further sample
// completes. Reset is synchronous; word_size returns to 16.
module dwvw_sample_decoder
  import dwvw_pkg::*;
#(
  parameter int MAX_WORD_SIZE = MAX_WS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,    // [7:0] data_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,   // [31:0] audio_sample
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [CFG_WS_W-1:0] ws_r, ws_nxt;
  logic                sel_ws;
  dp_cmd_t             cmd;
  dp_status_t          sts;

  assign cfg_pready = 1'b1;
  assign sel_ws     = (cfg_paddr[CFG_AW-1:2] == REG_WORD_SIZE);

  always_comb begin
    ws_nxt = ws_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_ws) begin
      ws_nxt = cfg_pwdata[CFG_WS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= CFG_WS_W'(WS_RST);
    end else begin
      ws_r <= ws_nxt;
    end
  end

  assign cfg_prdata = sel_ws ? CFG_DW'(ws_r) : '0;

  dwvw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwvw_dp #(
    .MAX_WORD_SIZE (MAX_WORD_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .word_size  (ws_r),
    .in_byte    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

@@ design/dwvw_chk.sv @@
// Port checker for the DWVW sample decoder, bound to the top level.
// Depends on dwvw_pkg; sees only the top-level ports.
module dwvw_chk
  import dwvw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic              out_tlast,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata,
  input logic              cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_byte_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready ##1 !in_tready
      ##1 !in_tready ##1 !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input taken again before the byte was decoded");

  a_reset_state: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready dropped");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[CFG_AW-1:2] == REG_WORD_SIZE)
      ##1 (cfg_paddr[CFG_AW-1:2] == REG_WORD_SIZE)
      |-> cfg_prdata == CFG_DW'($past(cfg_pwdata[CFG_WS_W-1:0])))
    else $error("word_size readback mismatch");

endmodule

bind dwvw_sample_decoder dwvw_chk u_chk (.*);
